// ===== rtl/multichannel_same_conv2d_assert.svh =====
// ----------------------------------------------------------------------------
// multichannel_same_conv2d assertion macros
// Shared property templates; the user scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAME_CONV2D_ASSERT_SVH
`define MULTICHANNEL_SAME_CONV2D_ASSERT_SVH

// Same-cycle implication.
`define MCSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsc_pkg
// Shared constants, types and helpers of the same-size conv2d block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcsc_pkg;

  localparam int KERN_ROWS   = 3;
  localparam int KERN_COLS   = 3;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int MAX_KERNELS = 4;

  localparam int KSIZE      = KERN_ROWS * KERN_COLS;
  localparam int MAPSIZE    = MAX_ROWS * MAX_COLS;
  localparam int FEAT_DEPTH = MAX_KERNELS * MAPSIZE;
  localparam int PAD_R      = KERN_ROWS / 2;
  localparam int PAD_C      = KERN_COLS / 2;

  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = PROD_W + $clog2(KSIZE);
  localparam int FEAT_W  = 48;
  localparam int IDX_W   = 6;
  localparam int REG_W   = 7;
  localparam int KSEL_W  = 2;
  localparam int KCNT_W  = 3;
  localparam int TK_W    = 3;
  localparam int TAP_W   = $clog2(KSIZE);
  localparam int KIDX_W  = $clog2(MAX_KERNELS);
  localparam int IMG_AW  = $clog2(MAPSIZE);
  localparam int FEAT_AW = $clog2(FEAT_DEPTH);
  localparam int TOT_W   = 2 * REG_W;
  localparam int SLOT    = KSIZE + 5;
  localparam int PH_W    = $clog2(SLOT);

  typedef enum logic [1:0] {
    FN_WEIGHT = 2'd0,
    FN_PIXEL  = 2'd1,
    FN_READ   = 2'd2,
    FN_BAD    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_KCNT  = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_t;

  // weight write into the cell row
  typedef struct packed {
    logic                     en;
    logic [TAP_W-1:0]         tap;
    logic [KIDX_W-1:0]        kern;
    logic signed [DATA_W-1:0] data;
  } wr_t;

  // per-cycle control of the cell row
  typedef struct packed {
    logic                     shift;
    logic                     mul;
    logic                     sum;
    logic [KIDX_W-1:0]        kern;
    logic signed [DATA_W-1:0] pix;
  } ctl_t;

  function automatic logic [REG_W-1:0] clamp_reg(logic [REG_W-1:0] v, logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) r = REG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [FEAT_AW-1:0] feat_addr(logic [KIDX_W-1:0] k,
                                                   logic [IDX_W-1:0] r,
                                                   logic [IDX_W-1:0] c);
    return FEAT_AW'(int'(k) * MAPSIZE + int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic signed [FEAT_W-1:0] sat_add(logic signed [FEAT_W-1:0] a,
                                                      logic signed [SUM_W-1:0] b);
    logic signed [FEAT_W:0] s;
    logic signed [FEAT_W-1:0] r;
    s = (FEAT_W+1)'(a) + (FEAT_W+1)'(b);
    if (s[FEAT_W] != s[FEAT_W-1]) r = s[FEAT_W] ? {1'b1, {(FEAT_W-1){1'b0}}}
                                                : {1'b0, {(FEAT_W-1){1'b1}}};
    else r = s[FEAT_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/mcsc_in_if.sv =====
// ----------------------------------------------------------------------------
// mcsc_in_if
// Input item channel: valid/ready with the item fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcsc_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       func;
  logic [mcsc_pkg::KSEL_W-1:0]      kernel_sel;
  logic [mcsc_pkg::IDX_W-1:0]       row_index;
  logic [mcsc_pkg::IDX_W-1:0]       col_index;
  logic signed [mcsc_pkg::DATA_W-1:0] data_value;
  logic                             first_channel;

  modport source (output valid, func, kernel_sel, row_index, col_index, data_value,
                  first_channel, input ready);
  modport sink   (input valid, func, kernel_sel, row_index, col_index, data_value,
                  first_channel, output ready);
endinterface

// ===== rtl/mcsc_out_if.sv =====
// ----------------------------------------------------------------------------
// mcsc_out_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mcsc_pkg::FEAT_W-1:0] read_value;
  logic                               channel_done;
  logic                               status;

  modport source (output valid, read_value, channel_done, status, input ready);
  modport sink   (input valid, read_value, channel_done, status, output ready);
endinterface

// ===== rtl/mcsc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mcsc_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcsc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [mcsc_pkg::REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mcsc_ram.sv =====
// ----------------------------------------------------------------------------
// mcsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mcsc_cell.sv =====
// ----------------------------------------------------------------------------
// mcsc_cell
// One kernel tap: its weights for all kernels, a pixel stage and a product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsc_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [mcsc_pkg::TAP_W-1:0]            cell_id,
  input  mcsc_pkg::wr_t                         wr,
  input  mcsc_pkg::ctl_t                        ctl,
  input  logic signed [mcsc_pkg::DATA_W-1:0]    pix_in,
  output logic signed [mcsc_pkg::DATA_W-1:0]    pix_out,
  output logic signed [mcsc_pkg::PROD_W-1:0]    prod
);

  logic signed [mcsc_pkg::DATA_W-1:0] w_r [mcsc_pkg::MAX_KERNELS];
  logic signed [mcsc_pkg::DATA_W-1:0] pix_r;
  logic signed [mcsc_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mcsc_pkg::MAX_KERNELS; k++) begin
        w_r[k] <= '0;
      end
    end else if (wr.en && wr.tap == cell_id) begin
      w_r[wr.kern] <= wr.data;
    end
  end

  // pixel moves one cell down the row per shift
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pix_r <= pix_in;
    end
    if (ctl.mul) begin
      prod_r <= pix_r * w_r[ctl.kern];
    end
  end

  assign pix_out = pix_r;
  assign prod    = prod_r;

endmodule

// ===== rtl/mcsc_chain.sv =====
// ----------------------------------------------------------------------------
// mcsc_chain
// Row of tap cells fed as a pixel shift line, plus a two-level product sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsc_chain (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mcsc_pkg::wr_t                        wr,
  input  mcsc_pkg::ctl_t                       ctl,
  output logic signed [mcsc_pkg::SUM_W-1:0]    sum
);

  localparam int HALF = mcsc_pkg::KSIZE / 2;

  logic signed [mcsc_pkg::DATA_W-1:0] pix  [mcsc_pkg::KSIZE];
  logic signed [mcsc_pkg::PROD_W-1:0] prod [mcsc_pkg::KSIZE];
  logic signed [mcsc_pkg::SUM_W-1:0]  sum_a_nxt, sum_b_nxt;
  logic signed [mcsc_pkg::SUM_W-1:0]  sum_a_r, sum_b_r;

  // cell i ends up holding window tap KSIZE-1-i after KSIZE shifts
  for (genvar i = 0; i < mcsc_pkg::KSIZE; i++) begin : g_cell
    mcsc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (mcsc_pkg::TAP_W'(i)),
      .wr      (wr),
      .ctl     (ctl),
      .pix_in  ((i == 0) ? ctl.pix : pix[(i == 0) ? 0 : i-1]),
      .pix_out (pix[i]),
      .prod    (prod[i])
    );
  end

  always_comb begin
    sum_a_nxt = '0;
    sum_b_nxt = '0;
    for (int i = 0; i < HALF; i++) begin
      sum_a_nxt = sum_a_nxt + mcsc_pkg::SUM_W'(prod[i]);
    end
    for (int i = HALF; i < mcsc_pkg::KSIZE; i++) begin
      sum_b_nxt = sum_b_nxt + mcsc_pkg::SUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  assign sum = sum_a_r + sum_b_r;

endmodule

// ===== rtl/multichannel_same_conv2d.sv =====
// ----------------------------------------------------------------------------
// multichannel_same_conv2d
// Same-size, zero-padded multichannel 2D convolution layer, forward pass.
// ----------------------------------------------------------------------------
// Channels: in_if carries items (func: weight write, channel pixel, feature
// read); out_if returns one result per item; cfg_if writes img_rows,
// img_cols and kernel_count (index 0..2, clamped to 1..max).
// Weight writes, bad items and non-final pixels: the result is registered on the
// transfer edge; a new item is taken every cycle while the receiver keeps up.
// Feature reads: the feature RAM read, then ST_READ and ST_FIN give the result.
// Last pixel of a channel: the cell row evaluates every output of every
// kernel in use, one image RAM read per tap, and then returns the result with
// channel_done set. No item is taken meanwhile.
// Reset: a clearing pass zeroes the 16384-entry feature RAM, in_if.ready low
// throughout; cfg writes are taken at any time.
// Stall: the output register holds its result; while idle, in_if.ready drops
// only when the register is full and out_if.ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multichannel_same_conv2d_assert.svh"

module multichannel_same_conv2d (
  input  logic   clk,
  input  logic   rst_n,
  mcsc_in_if.sink     in_if,
  mcsc_out_if.source  out_if,
  mcsc_cfg_if.sink    cfg_if
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CONV,
    ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [mcsc_pkg::REG_W-1:0]  rows_r, cols_r;
  logic [mcsc_pkg::KCNT_W-1:0] kcnt_r;
  logic [mcsc_pkg::TOT_W-1:0]  total;

  // channel bookkeeping
  logic [mcsc_pkg::IMG_AW-1:0] pos_r;
  logic                        ovw_r;      // overwrite flag of channel in flight
  logic                        conv_ow_r;  // overwrite flag used by the sweep

  // sweep counters
  logic [mcsc_pkg::KIDX_W-1:0] k_r;
  logic [mcsc_pkg::IDX_W-1:0]  r_r, c_r;
  logic [mcsc_pkg::PH_W-1:0]   ph_r;
  logic [mcsc_pkg::TK_W-1:0]   ti_r, tj_r;
  logic                        tap_ok_r;
  logic signed [mcsc_pkg::SUM_W-1:0] sum_r;

  // clear pass
  logic [mcsc_pkg::FEAT_AW-1:0] clr_r;

  // pending and output results
  logic signed [mcsc_pkg::FEAT_W-1:0] res_value_r;
  logic                               res_done_r;
  logic                               out_valid_r;
  logic signed [mcsc_pkg::FEAT_W-1:0] out_value_r;
  logic                               out_done_r, out_status_r;

  // decode
  mcsc_pkg::func_t fn;
  logic in_fire, out_fire, out_free, cfg_fire;
  logic ks_ok, wt_ok, rd_ok, last_pix, ow_now;
  logic load_now, load_fin, load;
  logic imm_status;

  // sweep datapath
  logic signed [8:0]  yy, xx;
  logic               tap_in;
  logic [mcsc_pkg::TOT_W-1:0]   lin;
  logic [mcsc_pkg::IMG_AW-1:0]  img_raddr;
  logic [mcsc_pkg::DATA_W-1:0]  img_q;
  logic [mcsc_pkg::FEAT_AW-1:0] conv_addr, feat_raddr, feat_waddr;
  logic [mcsc_pkg::FEAT_W-1:0]  feat_q, feat_wdata;
  logic                         feat_we;
  logic signed [mcsc_pkg::FEAT_W-1:0] feat_new;
  logic                         c_last, r_last, k_last, conv_last, ph_end;
  logic [mcsc_pkg::TAP_W-1:0]   wtap;

  mcsc_pkg::wr_t  wr;
  mcsc_pkg::ctl_t ctl;
  logic signed [mcsc_pkg::SUM_W-1:0] chain_sum;

  assign fn       = mcsc_pkg::func_t'(in_if.func);
  assign total    = mcsc_pkg::TOT_W'(rows_r) * mcsc_pkg::TOT_W'(cols_r);
  assign out_fire = out_valid_r && out_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire = cfg_if.valid;

  assign ks_ok = mcsc_pkg::KCNT_W'(in_if.kernel_sel) < kcnt_r;
  assign wt_ok = ks_ok && (int'(in_if.row_index) < mcsc_pkg::KERN_ROWS)
                       && (int'(in_if.col_index) < mcsc_pkg::KERN_COLS);
  assign rd_ok = ks_ok && (mcsc_pkg::REG_W'(in_if.row_index) < rows_r)
                       && (mcsc_pkg::REG_W'(in_if.col_index) < cols_r);
  assign last_pix = (mcsc_pkg::TOT_W'(pos_r) + mcsc_pkg::TOT_W'(1)) >= total;
  assign ow_now   = (pos_r == '0) ? in_if.first_channel : ovw_r;

  assign imm_status = ((fn == mcsc_pkg::FN_WEIGHT) && !wt_ok) ||
                      ((fn == mcsc_pkg::FN_READ) && !rd_ok) ||
                      (fn == mcsc_pkg::FN_BAD);
  assign load_now = in_fire && !((fn == mcsc_pkg::FN_READ) && rd_ok)
                            && !((fn == mcsc_pkg::FN_PIXEL) && last_pix);
  assign load_fin = (state_r == ST_FIN) && out_free;
  assign load     = load_now || load_fin;

  // weight write: cell i holds tap KSIZE-1-i
  assign wtap = mcsc_pkg::TAP_W'(int'(in_if.row_index) * mcsc_pkg::KERN_COLS
                                 + int'(in_if.col_index));
  always_comb begin
    wr.en   = in_fire && (fn == mcsc_pkg::FN_WEIGHT) && wt_ok;
    wr.tap  = mcsc_pkg::TAP_W'(mcsc_pkg::KSIZE - 1) - wtap;
    wr.kern = in_if.kernel_sel;
    wr.data = in_if.data_value;
  end

  // tap address of the window element being fetched
  always_comb begin
    yy = $signed({3'b000, r_r}) + $signed({6'b000000, ti_r})
         - $signed(9'(mcsc_pkg::PAD_R));
    xx = $signed({3'b000, c_r}) + $signed({6'b000000, tj_r})
         - $signed(9'(mcsc_pkg::PAD_C));
    tap_in = !yy[8] && !xx[8] && (yy < $signed({2'b00, rows_r}))
                              && (xx < $signed({2'b00, cols_r}));
    lin = mcsc_pkg::TOT_W'(yy[mcsc_pkg::IDX_W-1:0]) * mcsc_pkg::TOT_W'(cols_r)
          + mcsc_pkg::TOT_W'(xx[mcsc_pkg::IDX_W-1:0]);
    img_raddr = lin[mcsc_pkg::IMG_AW-1:0];
  end

  always_comb begin
    ctl.shift = (ph_r >= mcsc_pkg::PH_W'(1)) && (ph_r <= mcsc_pkg::PH_W'(mcsc_pkg::KSIZE));
    ctl.mul   = ph_r == mcsc_pkg::PH_W'(mcsc_pkg::KSIZE + 1);
    ctl.sum   = ph_r == mcsc_pkg::PH_W'(mcsc_pkg::KSIZE + 2);
    ctl.kern  = k_r;
    ctl.pix   = tap_ok_r ? $signed(img_q) : '0;
  end

  assign c_last    = mcsc_pkg::REG_W'(c_r) == cols_r - mcsc_pkg::REG_W'(1);
  assign r_last    = mcsc_pkg::REG_W'(r_r) == rows_r - mcsc_pkg::REG_W'(1);
  assign k_last    = mcsc_pkg::KCNT_W'(k_r) == kcnt_r - mcsc_pkg::KCNT_W'(1);
  assign ph_end    = ph_r == mcsc_pkg::PH_W'(mcsc_pkg::SLOT - 1);
  assign conv_last = (state_r == ST_CONV) && ph_end && c_last && r_last && k_last;

  assign conv_addr = mcsc_pkg::feat_addr(k_r, r_r, c_r);
  assign feat_new  = conv_ow_r ? mcsc_pkg::sat_add('0, sum_r)
                               : mcsc_pkg::sat_add($signed(feat_q), sum_r);

  always_comb begin
    feat_raddr = (state_r == ST_CONV) ? conv_addr
               : mcsc_pkg::feat_addr(in_if.kernel_sel, in_if.row_index, in_if.col_index);
    feat_we    = (state_r == ST_CLEAR) || ((state_r == ST_CONV) && ph_end);
    feat_waddr = (state_r == ST_CLEAR) ? clr_r : conv_addr;
    feat_wdata = (state_r == ST_CLEAR) ? '0 : feat_new;
  end

  mcsc_ram #(.WIDTH(mcsc_pkg::DATA_W), .DEPTH(mcsc_pkg::MAPSIZE)) u_img_ram (
    .clk   (clk),
    .we    (in_fire && (fn == mcsc_pkg::FN_PIXEL)),
    .waddr (pos_r),
    .wdata (in_if.data_value),
    .raddr (img_raddr),
    .rdata (img_q)
  );

  mcsc_ram #(.WIDTH(mcsc_pkg::FEAT_W), .DEPTH(mcsc_pkg::FEAT_DEPTH)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (feat_waddr),
    .wdata (feat_wdata),
    .raddr (feat_raddr),
    .rdata (feat_q)
  );

  mcsc_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .ctl   (ctl),
    .sum   (chain_sum)
  );

  // payload registers
  always_ff @(posedge clk) begin
    tap_ok_r <= (ph_r < mcsc_pkg::PH_W'(mcsc_pkg::KSIZE)) && tap_in;
    if (ph_r == mcsc_pkg::PH_W'(mcsc_pkg::KSIZE + 3)) begin
      sum_r <= chain_sum;
    end
    if (load_now) begin
      out_value_r  <= '0;
      out_done_r   <= 1'b0;
      out_status_r <= imm_status;
    end else if (load_fin) begin
      out_value_r  <= res_value_r;
      out_done_r   <= res_done_r;
      out_status_r <= 1'b0;
    end
    if (state_r == ST_READ) begin
      res_value_r <= $signed(feat_q);
      res_done_r  <= 1'b0;
    end else if (conv_last) begin
      res_value_r <= '0;
      res_done_r  <= 1'b1;
    end
    if (in_fire && (fn == mcsc_pkg::FN_PIXEL) && last_pix) begin
      conv_ow_r <= ow_now;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rows_r      <= mcsc_pkg::REG_W'(mcsc_pkg::MAX_ROWS);
      cols_r      <= mcsc_pkg::REG_W'(mcsc_pkg::MAX_COLS);
      kcnt_r      <= mcsc_pkg::KCNT_W'(mcsc_pkg::MAX_KERNELS);
      pos_r       <= '0;
      ovw_r       <= 1'b0;
      k_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      ph_r        <= '0;
      ti_r        <= '0;
      tj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + mcsc_pkg::FEAT_AW'(1);
          if (clr_r == mcsc_pkg::FEAT_AW'(mcsc_pkg::FEAT_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire && (fn == mcsc_pkg::FN_READ) && rd_ok) begin
            state_r <= ST_READ;
          end else if (in_fire && (fn == mcsc_pkg::FN_PIXEL)) begin
            if (last_pix) begin
              pos_r   <= '0;
              ovw_r   <= 1'b0;
              state_r <= ST_CONV;
            end else begin
              pos_r <= pos_r + mcsc_pkg::IMG_AW'(1);
              ovw_r <= ow_now;
            end
          end
        end
        ST_READ: begin
          state_r <= ST_FIN;
        end
        ST_CONV: begin
          if (ph_r < mcsc_pkg::PH_W'(mcsc_pkg::KSIZE)) begin
            if (int'(tj_r) == mcsc_pkg::KERN_COLS - 1) begin
              tj_r <= '0;
              ti_r <= ti_r + mcsc_pkg::TK_W'(1);
            end else begin
              tj_r <= tj_r + mcsc_pkg::TK_W'(1);
            end
          end
          if (ph_end) begin
            ph_r <= '0;
            ti_r <= '0;
            tj_r <= '0;
            if (c_last) begin
              c_r <= '0;
              if (r_last) begin
                r_r <= '0;
                if (k_last) begin
                  k_r     <= '0;
                  state_r <= ST_FIN;
                end else begin
                  k_r <= k_r + mcsc_pkg::KIDX_W'(1);
                end
              end else begin
                r_r <= r_r + mcsc_pkg::IDX_W'(1);
              end
            end else begin
              c_r <= c_r + mcsc_pkg::IDX_W'(1);
            end
          end else begin
            ph_r <= ph_r + mcsc_pkg::PH_W'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // size change restarts the channel
      if (cfg_fire) begin
        unique case (mcsc_pkg::cfg_reg_t'(cfg_if.index))
          mcsc_pkg::REG_ROWS: begin
            rows_r <= mcsc_pkg::clamp_reg(cfg_if.data, mcsc_pkg::REG_W'(mcsc_pkg::MAX_ROWS));
            pos_r  <= '0;
            ovw_r  <= 1'b0;
          end
          mcsc_pkg::REG_COLS: begin
            cols_r <= mcsc_pkg::clamp_reg(cfg_if.data, mcsc_pkg::REG_W'(mcsc_pkg::MAX_COLS));
            pos_r  <= '0;
            ovw_r  <= 1'b0;
          end
          mcsc_pkg::REG_KCNT: begin
            kcnt_r <= mcsc_pkg::KCNT_W'(mcsc_pkg::clamp_reg(
                        {{(mcsc_pkg::REG_W-mcsc_pkg::KCNT_W){1'b0}},
                         cfg_if.data[mcsc_pkg::KCNT_W-1:0]},
                        mcsc_pkg::REG_W'(mcsc_pkg::MAX_KERNELS)));
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.read_value   = out_value_r;
  assign out_if.channel_done = out_done_r;
  assign out_if.status       = out_status_r;

  `MCSC_ASSERT_IMP(a_pos_in_range, 1'b1, mcsc_pkg::TOT_W'(pos_r) < total,
                   "pixel position beyond channel size")
  `MCSC_ASSERT_IMP(a_load_free, load, !out_valid_r || out_if.ready,
                   "result loaded over an untaken result")
  `MCSC_ASSERT_IMP(a_feat_we, feat_we, (state_r == ST_CLEAR) || (state_r == ST_CONV),
                   "feature write outside clear or sweep")
  `MCSC_ASSERT_NXT(a_sweep_end, conv_last, (state_r == ST_FIN) && res_done_r,
                   "sweep end did not raise channel done")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the same-size multichannel conv2d block. A queued
// driver sends weight writes, channel pixels, feature reads and malformed
// items. Register writes go in between phases, once the block is idle. A
// predictor holds its own weights, image and feature maps. A
// monitor compares every result transfer, field by field, against the oldest
// expected result.
// ----------------------------------------------------------------------------

module tb_top;
  import mcsc_pkg::*;

  localparam longint FEAT_HI     = 64'sh7FFF_FFFF_FFFF;
  localparam longint FEAT_LO     = -FEAT_HI - 1;
  localparam int     CYCLE_LIMIT = 3_000_000;
  localparam int     HOLD_LEN    = 400;   // long receiver hold-off
  localparam int     SETTLE      = 20;    // idle cycles before a register write
  localparam int     ITEM_TARGET = 1550;  // random phases stop past this many items

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN, OP_HOLD} op_kind_t;

  typedef struct {
    op_kind_t                 kind;
    func_t                    func;
    logic [KSEL_W-1:0]        ksel;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] data;
    logic                     first;
    cfg_reg_t                 reg_idx;
    logic [REG_W-1:0]         reg_val;
  } op_t;

  typedef struct {
    logic [FEAT_W-1:0] read_value;
    logic              channel_done;
    logic              status;
  } conv_result_t;

  logic clk;
  logic rst_n;

  mcsc_in_if  in_if();
  mcsc_out_if out_if();
  mcsc_cfg_if cfg_if();

  multichannel_same_conv2d DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the block's registers and stores.
  // --------------------------------------------------------------------------
  int unsigned     n_rows, n_cols, n_kern;
  shortint         kern_w[MAX_KERNELS][KSIZE];
  shortint         chan_pix[MAPSIZE];
  longint          fmap[MAX_KERNELS][MAX_ROWS][MAX_COLS];
  int unsigned     pix_pos;
  bit              ovw_pending;

  op_t             pending_ops[$];
  conv_result_t    expected_results[$];

  int              errors;
  int              items_sent, channels_done, reads_ok, status_errs;
  int              items_planned;
  int              hold_seq, hold_seen;
  int              cycles;

  // --------------------------------------------------------------------------
  // Clock and reset: reset held low once, at the start.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // all block inputs known from time zero
  initial begin
    in_if.valid         = 1'b0;
    in_if.func          = FN_WEIGHT;
    in_if.kernel_sel    = '0;
    in_if.row_index     = '0;
    in_if.col_index     = '0;
    in_if.data_value    = '0;
    in_if.first_channel = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_ROWS;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor functions
  // --------------------------------------------------------------------------
  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint feat_sat(longint s);
    if (s > FEAT_HI) return FEAT_HI;
    if (s < FEAT_LO) return FEAT_LO;
    return s;
  endfunction

  function automatic void predictor_reset();
    n_rows      = MAX_ROWS;
    n_cols      = MAX_COLS;
    n_kern      = MAX_KERNELS;
    pix_pos     = 0;
    ovw_pending = 1'b0;
    foreach (kern_w[k, t]) kern_w[k][t] = 0;
    foreach (chan_pix[i]) chan_pix[i] = 0;
    foreach (fmap[k, r, c]) fmap[k][r][c] = 0;
  endfunction

  function automatic void apply_reg_write(cfg_reg_t idx, logic [REG_W-1:0] v);
    case (idx)
      REG_ROWS: begin
        n_rows      = clamp_to(v, MAX_ROWS);
        pix_pos     = 0;
        ovw_pending = 1'b0;
      end
      REG_COLS: begin
        n_cols      = clamp_to(v, MAX_COLS);
        pix_pos     = 0;
        ovw_pending = 1'b0;
      end
      REG_KCNT: n_kern = clamp_to(v[KCNT_W-1:0], MAX_KERNELS);
      default: ;
    endcase
  endfunction

  // zero-padded same-size cross-correlation of the channel into every map in use
  function automatic void accumulate_channel();
    longint sum;
    int     y, x;
    for (int k = 0; k < n_kern; k++)
      for (int r = 0; r < n_rows; r++)
        for (int c = 0; c < n_cols; c++) begin
          sum = 0;
          for (int i = 0; i < KERN_ROWS; i++) begin
            y = r + i - PAD_R;
            if (y < 0 || y >= n_rows) continue;
            for (int j = 0; j < KERN_COLS; j++) begin
              x = c + j - PAD_C;
              if (x < 0 || x >= n_cols) continue;
              sum += longint'(kern_w[k][i*KERN_COLS + j]) * longint'(chan_pix[y*n_cols + x]);
            end
          end
          fmap[k][r][c] = ovw_pending ? feat_sat(sum) : feat_sat(fmap[k][r][c] + sum);
        end
  endfunction

  function automatic conv_result_t predict_item(op_t it);
    conv_result_t res;
    int unsigned  total;
    res = '{read_value: '0, channel_done: 1'b0, status: 1'b0};
    case (it.func)
      FN_WEIGHT: begin
        if (it.ksel >= n_kern || it.row >= KERN_ROWS || it.col >= KERN_COLS) res.status = 1'b1;
        else kern_w[it.ksel][it.row*KERN_COLS + it.col] = it.data;
      end
      FN_PIXEL: begin
        total = n_rows * n_cols;
        if (pix_pos >= total) pix_pos = 0;
        if (pix_pos == 0) ovw_pending = it.first;
        chan_pix[pix_pos] = it.data;
        if (pix_pos + 1 >= total) begin
          accumulate_channel();
          res.channel_done = 1'b1;
          pix_pos          = 0;
          ovw_pending      = 1'b0;
        end else begin
          pix_pos++;
        end
      end
      FN_READ: begin
        if (it.ksel >= n_kern || it.row >= n_rows || it.col >= n_cols) res.status = 1'b1;
        else res.read_value = fmap[it.ksel][it.row][it.col][FEAT_W-1:0];
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic void push_item(func_t f, int k, int r, int c,
                                    logic signed [DATA_W-1:0] d, bit fc);
    op_t o;
    o = '{kind: OP_ITEM, func: f, ksel: KSEL_W'(k), row: IDX_W'(r), col: IDX_W'(c),
          data: d, first: fc, reg_idx: REG_NONE, reg_val: '0};
    pending_ops.insert(pending_ops.size(), o);
    items_planned++;
  endfunction

  function automatic void push_noise();
    push_item(func_t'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom_range(0, 63),
              $urandom_range(0, 63), DATA_W'($urandom), bit'($urandom_range(0, 1)));
  endfunction

  function automatic void push_cfg(cfg_reg_t idx, int v);
    op_t o;
    o = '{kind: OP_CFG, func: FN_WEIGHT, ksel: '0, row: '0, col: '0, data: '0,
          first: 1'b0, reg_idx: idx, reg_val: REG_W'(v)};
    pending_ops.insert(pending_ops.size(), o);
  endfunction

  function automatic void push_mark(op_kind_t kd);
    op_t o;
    o = '{kind: kd, func: FN_WEIGHT, ksel: '0, row: '0, col: '0, data: '0, first: 1'b0,
          reg_idx: REG_NONE, reg_val: '0};
    pending_ops.insert(pending_ops.size(), o);
  endfunction

  // gap before the next transfer: mostly none, some short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plan. Sizes are mostly small so each channel pass stays short;
  // a few phases use a dimension at its maximum.
  // --------------------------------------------------------------------------
  initial begin
    int raw_r, raw_c, raw_k, eff_r, eff_c, eff_k, n_ch, sel;

    items_planned = 0;
    predictor_reset();

    // directed: reset sizes 64x64, 4 kernels
    push_item(FN_READ, 3, 63, 63, 16'sh0, 1'b0);           // far corner, untouched map
    push_item(FN_READ, 0, 0, 0, 16'sh0, 1'b0);
    push_item(FN_READ, 0, 63, 0, 16'sh0, 1'b0);
    push_item(FN_WEIGHT, 0, 0, 0, 16'sh8000, 1'b0);
    push_item(FN_WEIGHT, 3, 2, 2, 16'sh7FFF, 1'b0);
    push_item(FN_WEIGHT, 1, 3, 0, 16'sh1234, 1'b0);         // weight row past kernel
    push_item(FN_WEIGHT, 2, 0, 63, 16'sh1234, 1'b0);        // weight column past kernel
    push_item(FN_BAD, 3, 63, 63, 16'shFFFF, 1'b1);          // undefined func
    push_item(FN_PIXEL, 0, 0, 0, 16'sh0100, 1'b1);          // pixels restarted below
    push_item(FN_PIXEL, 3, 63, 63, 16'sh8000, 1'b0);
    // out-of-range register values clamp; a size write restarts the channel
    push_cfg(REG_ROWS, 0);
    push_cfg(REG_COLS, 127);
    push_cfg(REG_KCNT, 0);
    push_cfg(REG_NONE, 5);
    push_item(FN_WEIGHT, 1, 0, 0, 16'sh0100, 1'b0);         // kernel not in use
    push_item(FN_READ, 1, 0, 0, 16'sh0, 1'b0);              // kernel not in use
    push_item(FN_READ, 0, 1, 0, 16'sh0, 1'b0);              // row beyond img_rows
    push_item(FN_READ, 0, 0, 63, 16'sh0, 1'b0);
    for (int c = 0; c < 64; c++) push_item(FN_PIXEL, 0, 0, 0, pick_data(), c == 0);
    push_item(FN_READ, 0, 0, 63, 16'sh0, 1'b0);
    push_cfg(REG_ROWS, 64);
    push_cfg(REG_COLS, 1);
    push_cfg(REG_KCNT, 7);
    for (int r = 0; r < 64; r++) push_item(FN_PIXEL, 0, 0, 0, pick_data(), 1'b0);
    push_item(FN_READ, 3, 63, 0, 16'sh0, 1'b0);
    push_item(FN_READ, 0, 63, 0, 16'sh0, 1'b0);
    // long receiver freeze with the sender still offering, then a full drain
    push_mark(OP_HOLD);
    repeat (12) push_item(FN_READ, $urandom_range(0, 3), $urandom_range(0, 63), 0,
                          16'sh0, 1'b0);
    push_mark(OP_DRAIN);

    // random phases
    while (items_planned < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        raw_r = 64; raw_c = $urandom_range(1, 2);
      end else if (sel == 1) begin
        raw_r = $urandom_range(0, 2); raw_c = $urandom_range(64, 127);
      end else begin
        raw_r = $urandom_range(0, 6); raw_c = $urandom_range(1, 6);
      end
      raw_k = $urandom_range(0, 7);
      eff_r = clamp_to(raw_r, MAX_ROWS);
      eff_c = clamp_to(raw_c, MAX_COLS);
      eff_k = clamp_to(raw_k, MAX_KERNELS);
      push_cfg(REG_KCNT, raw_k);
      push_cfg(REG_ROWS, raw_r);
      push_cfg(REG_COLS, raw_c);

      for (int k = 0; k < eff_k; k++)
        for (int t = 0; t < KSIZE; t++)
          if ($urandom_range(0, 3) != 0)
            push_item(FN_WEIGHT, k, t / KERN_COLS, t % KERN_COLS, pick_data(), 1'b0);

      // receiver freezes while the sender keeps offering quick items
      if ($urandom_range(0, 6) == 0) begin
        push_mark(OP_HOLD);
        repeat (12) push_item(FN_READ, $urandom_range(0, eff_k-1), $urandom_range(0, eff_r-1),
                              $urandom_range(0, eff_c-1), 16'sh0, 1'b0);
      end

      n_ch = $urandom_range(1, 3);
      for (int ch = 0; ch < n_ch; ch++) begin
        for (int p = 0; p < eff_r * eff_c; p++) begin
          push_item(FN_PIXEL, $urandom_range(0, 3), $urandom_range(0, 63),
                    $urandom_range(0, 63), pick_data(), bit'($urandom_range(0, 1)));
          if ($urandom_range(0, 15) == 0) push_noise();
        end
        if ($urandom_range(0, 3) == 0) push_mark(OP_DRAIN);
      end

      repeat ($urandom_range(3, 10))
        push_item(FN_READ, $urandom_range(0, eff_k-1), $urandom_range(0, eff_r-1),
                  $urandom_range(0, eff_c-1), 16'sh0, 1'b0);
      repeat ($urandom_range(1, 4)) push_noise();
    end
  end

  // --------------------------------------------------------------------------
  // Driver: one nonblocking write per signal per edge. The predictor runs
  // at the transfer edge, so expectations follow acceptance order.
  // --------------------------------------------------------------------------
  int   gap_left;
  int   settle_left;
  op_t  in_flight;

  always @(posedge clk) begin
    bit  in_busy, cfg_busy;
    op_t nxt;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      cfg_if.valid <= 1'b0;
      gap_left     = 0;
      settle_left  = SETTLE;
      hold_seq     <= 0;
    end else begin
      in_busy  = in_if.valid;
      cfg_busy = cfg_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_results.insert(expected_results.size(), predict_item(in_flight));
        items_sent++;
        in_busy = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_reg_write(cfg_reg_t'(cfg_if.index), cfg_if.data);
        cfg_busy = 1'b0;
      end
      if (expected_results.size() != 0 || in_busy) settle_left = SETTLE;

      if (!in_busy && !cfg_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops[0];
          case (nxt.kind)
            OP_ITEM: begin
              void'(pending_ops.pop_front());
              in_flight              = nxt;
              in_if.func            <= nxt.func;
              in_if.kernel_sel      <= nxt.ksel;
              in_if.row_index       <= nxt.row;
              in_if.col_index       <= nxt.col;
              in_if.data_value      <= nxt.data;
              in_if.first_channel   <= nxt.first;
              in_busy                = 1'b1;
              gap_left               = pick_gap();
            end
            OP_CFG: begin
              // register writes only once every result is back and the block sits idle
              if (settle_left > 0) begin
                settle_left--;
              end else begin
                void'(pending_ops.pop_front());
                cfg_if.index <= nxt.reg_idx;
                cfg_if.data  <= nxt.reg_val;
                cfg_busy      = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (expected_results.size() == 0) void'(pending_ops.pop_front());
            end
            OP_HOLD: begin
              void'(pending_ops.pop_front());
              hold_seq <= hold_seq + 1;
            end
          endcase
        end
      end
      in_if.valid  <= in_busy;
      cfg_if.valid <= cfg_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and receiver back-pressure
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [FEAT_W-1:0] got, logic [FEAT_W-1:0] exp);
    $display("%0t: %s got %0h, expected %0h", $realtime, field, got, exp);
    errors++;
  endtask

  int hold_left;
  int stall_left;

  always @(posedge clk) begin
    conv_result_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left     = 0;
      stall_left    = 0;
      hold_seen     = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transfer", out_if.read_value, '0);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_if.read_value !== exp_r.read_value)
            report_mismatch("read_value", out_if.read_value, exp_r.read_value);
          if (out_if.channel_done !== exp_r.channel_done)
            report_mismatch("channel_done", FEAT_W'(out_if.channel_done),
                            FEAT_W'(exp_r.channel_done));
          if (out_if.status !== exp_r.status)
            report_mismatch("status", FEAT_W'(out_if.status), FEAT_W'(exp_r.status));
          if (exp_r.channel_done) channels_done++;
          if (exp_r.status) status_errs++;
          else if (exp_r.read_value != 0) reads_ok++;
        end
      end

      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left    = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of run and timeout
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    errors = 0; items_sent = 0; channels_done = 0; reads_ok = 0; status_errs = 0;
    cycles = 0;
    @(posedge rst_n);
    @(posedge clk);
    wait (pending_ops.size() == 0 && !in_if.valid && !cfg_if.valid &&
          expected_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("Run covered %0d items, %0d completed channels, %0d nonzero feature reads,",
             items_sent, channels_done, reads_ok);
    $display("%0d rejected items, over %0d cycles with random stalls on both sides.",
             status_errs, cycles);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
